[rtl/rpy_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roll, pitch, yaw rotation package
// Shared widths, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package rpy_pkg;

  localparam int unsigned AngW = 16;
  localparam int unsigned OutW = 16;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned OutFracBits = 14;
  localparam int unsigned TurnUnits = 46080;
  localparam int unsigned HalfTurn = 23040;
  localparam int unsigned VW = 34;
  localparam logic signed [VW-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [VW-1:0] val_t;

  function automatic logic [31:0] atan_phase(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic val_t mulq30(input val_t a, input val_t b);
    logic signed [2*VW-1:0] p;
    p = a * b + (64'sd1 <<< 29);
    return VW'(p >>> 30);
  endfunction

  function automatic logic [OutW-1:0] to_out(input val_t v);
    val_t r;
    val_t lim;
    lim = val_t'(1) <<< OutFracBits;
    if (OutFracBits < 30) begin
      r = (v + (val_t'(1) <<< (29 - OutFracBits))) >>> (30 - OutFracBits);
    end else begin
      r = v;
    end
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[OutW-1:0];
  endfunction

endpackage

[rtl/rpy_sincos.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine pipeline
// Angle to phase, quadrant fold and one CORDIC step per register stage.
// ----------------------------------------------------------------------------
module rpy_sincos import rpy_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AngW-1:0] ang_i,
  output val_t            cos_o,
  output val_t            sin_o
);

  localparam int unsigned NS = CordicSteps;
  localparam int unsigned TurnDiv = TurnUnits >> 10;
  localparam int unsigned HalfRound = HalfTurn >> 10;
  localparam int unsigned RemStep = (1 << 22) / TurnDiv;
  localparam int unsigned RemFrac = (1 << 22) % TurnDiv;
  localparam int unsigned DivRecip = ((1 << 22) + TurnDiv - 1) / TurnDiv;
  localparam int unsigned FracRecip = ((1 << 17) + TurnDiv - 1) / TurnDiv;

  logic [15:0] a_q;
  logic [9:0] h_q;
  logic [15:0] ar_q;
  logic [31:0] ph_q;
  val_t x_q [NS+1];
  val_t y_q [NS+1];
  logic signed [32:0] z_q [NS+1];
  logic [1:0] qd_q [NS+1];
  val_t c_q, s_q;

  logic [15:0] a_d;
  logic [31:0] d_d;
  logic [1:0] q_d;
  logic [5:0] r_d;
  logic [31:0] rfrac_d;
  logic [21:0] f_d;

  always_comb begin
    a_d = ang_i[15] ? 16'(17'(ang_i) + 17'(TurnUnits) - 17'h10000) : ang_i;
    r_d = 6'(ar_q - 16'(h_q) * 16'(TurnDiv));
    rfrac_d = ((32'(r_d) * RemFrac + HalfRound) * FracRecip) >> 17;
    f_d = 22'(32'(r_d) * RemStep + rfrac_d);
    q_d = 2'((ph_q + 32'h2000_0000) >> 30);
    d_d = ph_q - {q_d, 30'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      h_q <= 10'((33'(a_q) * 33'(DivRecip)) >> 22);
      ar_q <= a_q;
      ph_q <= {h_q, f_d};
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      z_q[0] <= 33'(signed'(d_d));
      qd_q[0] <= q_d;
      for (int i = 0; i < NS; i++) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - 33'(atan_phase(5'(i)));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + 33'(atan_phase(5'(i)));
        end
        qd_q[i+1] <= qd_q[i];
      end
      case (qd_q[NS])
        2'd0: begin c_q <= x_q[NS]; s_q <= y_q[NS]; end
        2'd1: begin c_q <= -y_q[NS]; s_q <= x_q[NS]; end
        2'd2: begin c_q <= -x_q[NS]; s_q <= -y_q[NS]; end
        default: begin c_q <= y_q[NS]; s_q <= -x_q[NS]; end
      endcase
    end
  end

  assign cos_o = c_q;
  assign sin_o = s_q;

endmodule

[rtl/roll_pitch_yaw_to_rotation_matrix_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roll, pitch, yaw to rotation matrix
// Forms R = Rz(yaw) * Ry(pitch) * Rx(roll) in Q2.14 from signed angles in 1/128 degree units.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata fields (low bit first)          | Width
//  s_axis  | in  | roll_angle, pitch_angle, yaw_angle     | 48
//  m_axis  | out | m00 m01 m02 m10 m11 m12 m20 m21 m22    | 144
//
// One request enters per cycle unless the output stage holds a result that is not taken.
// The pipeline advances as one unit when its output stage is empty or taken.
// Reset clears only the valid bits of the stages.
module roll_pitch_yaw_to_rotation_matrix_unit import rpy_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [47:0]   s_axis_tdata_i,  // roll_angle, pitch_angle, yaw_angle
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [143:0]  m_axis_tdata_o   // m00 m01 m02 m10 m11 m12 m20 m21 m22
);

  localparam int unsigned Lat = CordicSteps + 8;

  logic en;
  logic [Lat-1:0] vld_q;
  val_t cg, sg, cb, sb, ca, sa;
  val_t casb_q, sasb_q, cb2_q, sb2_q, cg2_q, sg2_q, ca2_q, sa2_q;
  val_t p0_q, p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q, p8_q, p9_q, p10_q, p11_q;
  val_t sb2_q_d2;
  logic [143:0] dat_q;

  assign en = !vld_q[Lat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  rpy_sincos u_roll (.clk_i, .en_i(en), .ang_i(s_axis_tdata_i[15:0]), .cos_o(cg), .sin_o(sg));
  rpy_sincos u_pitch (.clk_i, .en_i(en), .ang_i(s_axis_tdata_i[31:16]), .cos_o(cb), .sin_o(sb));
  rpy_sincos u_yaw (.clk_i, .en_i(en), .ang_i(s_axis_tdata_i[47:32]), .cos_o(ca), .sin_o(sa));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      casb_q <= mulq30(ca, sb);
      sasb_q <= mulq30(sa, sb);
      cb2_q <= cb; sb2_q <= sb; cg2_q <= cg; sg2_q <= sg; ca2_q <= ca; sa2_q <= sa;
      p0_q <= mulq30(ca2_q, cb2_q);
      p1_q <= mulq30(casb_q, sg2_q);
      p2_q <= mulq30(sa2_q, cg2_q);
      p3_q <= mulq30(casb_q, cg2_q);
      p4_q <= mulq30(sa2_q, sg2_q);
      p5_q <= mulq30(sa2_q, cb2_q);
      p6_q <= mulq30(sasb_q, sg2_q);
      p7_q <= mulq30(ca2_q, cg2_q);
      p8_q <= mulq30(sasb_q, cg2_q);
      p9_q <= mulq30(ca2_q, sg2_q);
      p10_q <= mulq30(cb2_q, sg2_q);
      p11_q <= mulq30(cb2_q, cg2_q);
      dat_q[15:0] <= to_out(p0_q);
      dat_q[31:16] <= to_out(p1_q - p2_q);
      dat_q[47:32] <= to_out(p3_q + p4_q);
      dat_q[63:48] <= to_out(p5_q);
      dat_q[79:64] <= to_out(p6_q + p7_q);
      dat_q[95:80] <= to_out(p8_q - p9_q);
      dat_q[111:96] <= to_out(-sb2_q_d2);
      dat_q[127:112] <= to_out(p10_q);
      dat_q[143:128] <= to_out(p11_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb2_q_d2 <= sb2_q;
    end
  end

  assign m_axis_tvalid_o = vld_q[Lat-1];
  assign m_axis_tdata_o = dat_q;

endmodule
